/* sv/sdm_pkg.sv */
// shared types, constants and codes for the spectral distortion metrics block
package sdm_pkg;

  // fixed field widths
  localparam int SAMPLE_W      = 20;
  localparam int MAX_SIZE_LOG2 = 15;
  localparam int PWR_W         = 56;
  localparam int BIN_W         = 15;
  localparam int PHASE_W       = 14;
  localparam int SIZE_W        = 4;
  localparam int CFG_W         = 15;
  localparam int CFG_IDX_W     = 1;

  // saturation ceiling of every power and sum
  localparam logic [PWR_W-1:0] PWR_MAX = {PWR_W{1'b1}};

  // register reset values
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(10);
  localparam logic [BIN_W-1:0]  FUND_RST = BIN_W'(1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_LOG2 = 1'b0,
    CFG_FUND_BIN  = 1'b1
  } cfg_reg_t;

  // input transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] bin_real;
    logic signed [SAMPLE_W-1:0] bin_imag;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [PWR_W-1:0] peak_power;
    logic [PWR_W-1:0] fund_power;
    logic [PWR_W-1:0] harmonic_power;
    logic [PWR_W-1:0] noise_power;
    logic             noise_found;
    logic [PWR_W-1:0] noise_dist_power;
    logic [PWR_W-1:0] spur_power;
    logic [BIN_W-1:0] spur_bin;
    logic             saturated;
  } out_item_t;

  // per-bin classification that travels with the data
  typedef struct packed {
    logic [BIN_W-1:0] idx;
    logic             dc;
    logic             fund;
    logic             mult;
    logic             harm;
    logic             spur;
    logic             last;
  } bin_tag_t;

  // stage load enables from the top level
  typedef struct packed {
    logic ld2;
    logic ld3;
  } pipe_ld_t;

  // stage occupancy back to the top level
  typedef struct packed {
    logic v2;
    logic v3;
  } pipe_vld_t;

endpackage

/* sv/spectral_distortion_metrics.sv */
// top level: bin classification, accumulators and result register
//
// Usage: FFT bins 0..N/2 (N = 2^size_log2) enter in order on the in_ channel,
// one valid/ready transaction per bin, as signed real/imaginary pairs. After
// the last bin of a frame one result transaction leaves on the out_ channel
// with peak, fundamental, harmonic, noise and noise-plus-distortion powers,
// the largest spur with its bin, and flags for noise found and saturation.
// Throughput is one bin per cycle: the path is an input register, a square
// stage, a power stage and the accumulators, each one register deep.
// The result register loads when the last bin of a frame leaves the power
// stage; while the result waits there, bins of the next frame keep flowing.
// Only when the next frame's last bin reaches the accumulators with the old
// result still untaken does the pipe stall, and in_ready drops back through
// the stages that are full. Registers are written on cfg_we, by the user
// only while the block is idle, which the block does not enforce; any write
// clears the frame in progress. Synchronous reset restores size_log2 = 10 and
// fundamental_bin = 1 and empties the pipe and all accumulators.
module spectral_distortion_metrics (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sdm_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sdm_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [sdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdm_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int SW     = sdm_pkg::SAMPLE_W;
  localparam int PW     = sdm_pkg::PWR_W;
  localparam int BW     = sdm_pkg::BIN_W;
  localparam int HALF_W = BW + 1;

  // configuration and frame counters
  logic [sdm_pkg::SIZE_W-1:0]  size_r;
  logic [BW-1:0]               fund_r;
  logic [BW-1:0]               bin_cnt_r;
  logic [BW-1:0]               bin_cnt_nxt;
  logic [sdm_pkg::PHASE_W-1:0] phase_r;
  logic [sdm_pkg::PHASE_W-1:0] phase_nxt;
  logic [sdm_pkg::SIZE_W-1:0]  size_eff;
  logic [HALF_W-1:0]           half;
  logic [HALF_W-1:0]           bin_w;
  logic [HALF_W-1:0]           fund_w;
  logic [BW-1:0]               phase_inc;
  logic                        far;
  sdm_pkg::bin_tag_t           tag_nxt;

  // input register
  logic                        v1_r;
  logic [SW-1:0]               mag_re_r;
  logic [SW-1:0]               mag_im_r;
  logic [SW-1:0]               mag_re_nxt;
  logic [SW-1:0]               mag_im_nxt;
  logic [SW-1:0]               raw_re;
  logic [SW-1:0]               raw_im;
  sdm_pkg::bin_tag_t           tag1_r;

  // pipe control
  sdm_pkg::pipe_ld_t           ld;
  sdm_pkg::pipe_vld_t          vld;
  logic                        ld1;
  logic                        hold3;
  logic                        fire;
  logic                        in_acc;
  logic [PW-1:0]               pwr;
  logic                        pwr_clip;
  sdm_pkg::bin_tag_t           tag3;

  // accumulators
  logic [PW-1:0]               peak_r;
  logic [PW-1:0]               peak_nxt;
  logic [PW-1:0]               fund_acc_r;
  logic [PW-1:0]               fund_acc_nxt;
  logic [PW-1:0]               harm_r;
  logic [PW-1:0]               harm_nxt;
  logic [PW-1:0]               noise_r;
  logic [PW-1:0]               noise_nxt;
  logic [PW-1:0]               nd_r;
  logic [PW-1:0]               nd_nxt;
  logic [PW-1:0]               spur_r;
  logic [PW-1:0]               spur_nxt;
  logic [BW-1:0]               spur_idx_r;
  logic [BW-1:0]               spur_idx_nxt;
  logic                        noise_seen_r;
  logic                        noise_seen_nxt;
  logic                        clip_r;
  logic                        clip_nxt;
  logic [PW:0]                 harm_sum;
  logic [PW:0]                 noise_sum;
  logic [PW:0]                 nd_sum;

  // result register
  logic                        out_valid_r;
  sdm_pkg::out_item_t          out_data_r;
  sdm_pkg::out_item_t          out_data_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= sdm_pkg::SIZE_RST;
      fund_r <= sdm_pkg::FUND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdm_pkg::CFG_SIZE_LOG2: size_r <= cfg_wdata[sdm_pkg::SIZE_W-1:0];
        sdm_pkg::CFG_FUND_BIN:  fund_r <= cfg_wdata[BW-1:0];
      endcase
    end
  end

  // frame geometry
  always_comb begin
    size_eff = size_r;
    if (size_r < sdm_pkg::SIZE_W'(2)) size_eff = sdm_pkg::SIZE_W'(2);
    if (size_r > sdm_pkg::SIZE_W'(sdm_pkg::MAX_SIZE_LOG2)) begin
      size_eff = sdm_pkg::SIZE_W'(sdm_pkg::MAX_SIZE_LOG2);
    end
    half   = HALF_W'(1) << (size_eff - sdm_pkg::SIZE_W'(1));
    fund_w = {1'b0, fund_r};
    bin_w  = {1'b0, bin_cnt_r};
    far    = (fund_r == '0) || (fund_w > half);
  end

  // classify the bin being accepted
  always_comb begin
    tag_nxt.idx  = bin_cnt_r;
    tag_nxt.dc   = (bin_cnt_r == '0);
    tag_nxt.fund = !far && (bin_cnt_r == fund_r);
    tag_nxt.mult = !far && (phase_r == '0);
    tag_nxt.harm = tag_nxt.mult && (bin_w >= {fund_r, 1'b0});
    tag_nxt.spur = !far && (bin_w >= fund_w + HALF_W'(1)) &&
                   ((fund_r == BW'(1)) || (phase_r == sdm_pkg::PHASE_W'(1)));
    tag_nxt.last = (bin_w >= half);
  end

  // bin index and position within the fundamental period
  always_comb begin
    phase_inc   = {1'b0, phase_r} + BW'(1);
    bin_cnt_nxt = tag_nxt.last ? '0 : bin_cnt_r + BW'(1);
    phase_nxt   = phase_r;
    if (tag_nxt.last) begin
      phase_nxt = '0;
    end else if (!far) begin
      phase_nxt = (phase_inc >= fund_r) ? '0 : phase_inc[sdm_pkg::PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      bin_cnt_r <= '0;
      phase_r   <= '0;
    end else if (in_acc) begin
      bin_cnt_r <= bin_cnt_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // magnitudes of the two's-complement components
  always_comb begin
    raw_re     = in_data.bin_real;
    raw_im     = in_data.bin_imag;
    mag_re_nxt = raw_re[SW-1] ? (~raw_re + SW'(1)) : raw_re;
    mag_im_nxt = raw_im[SW-1] ? (~raw_im + SW'(1)) : raw_im;
  end

  // stall only when a frame end meets an untaken result
  assign hold3    = vld.v3 && tag3.last && out_valid_r && !out_ready;
  assign ld.ld3   = !hold3;
  assign ld.ld2   = ld.ld3 || !vld.v2;
  assign ld1      = ld.ld2 || !v1_r;
  assign in_ready = ld1;
  assign in_acc   = in_valid && ld1;
  assign fire     = vld.v3 && !hold3;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      mag_re_r <= mag_re_nxt;
      mag_im_r <= mag_im_nxt;
      tag1_r   <= tag_nxt;
    end
  end

  sdm_power u_power (
    .clk      (clk),
    .rst_n    (rst_n),
    .v1       (v1_r),
    .mag_re   (mag_re_r),
    .mag_im   (mag_im_r),
    .tag1     (tag1_r),
    .ld       (ld),
    .vld      (vld),
    .pwr      (pwr),
    .pwr_clip (pwr_clip),
    .tag3     (tag3)
  );

  // saturating sums
  assign harm_sum  = {1'b0, harm_r}  + {1'b0, pwr};
  assign noise_sum = {1'b0, noise_r} + {1'b0, pwr};
  assign nd_sum    = {1'b0, nd_r}    + {1'b0, pwr};

  // accumulator update for one bin
  always_comb begin
    peak_nxt       = peak_r;
    fund_acc_nxt   = fund_acc_r;
    harm_nxt       = harm_r;
    noise_nxt      = noise_r;
    nd_nxt         = nd_r;
    spur_nxt       = spur_r;
    spur_idx_nxt   = spur_idx_r;
    noise_seen_nxt = noise_seen_r;
    clip_nxt       = clip_r;
    if (fire) begin
      if (pwr > peak_r) peak_nxt = pwr;
      if (pwr_clip) clip_nxt = 1'b1;
      if (!tag3.dc) begin
        if (tag3.fund) begin
          fund_acc_nxt = pwr;
        end else begin
          nd_nxt = nd_sum[PW] ? sdm_pkg::PWR_MAX : nd_sum[PW-1:0];
          if (nd_sum[PW]) clip_nxt = 1'b1;
        end
        if (tag3.mult) begin
          if (tag3.harm) begin
            harm_nxt = harm_sum[PW] ? sdm_pkg::PWR_MAX : harm_sum[PW-1:0];
            if (harm_sum[PW]) clip_nxt = 1'b1;
          end
        end else begin
          noise_nxt      = noise_sum[PW] ? sdm_pkg::PWR_MAX : noise_sum[PW-1:0];
          noise_seen_nxt = 1'b1;
          if (noise_sum[PW]) clip_nxt = 1'b1;
        end
        if (tag3.spur && (pwr > spur_r)) begin
          spur_nxt     = pwr;
          spur_idx_nxt = tag3.idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || (fire && tag3.last)) begin
      peak_r       <= '0;
      fund_acc_r   <= '0;
      harm_r       <= '0;
      noise_r      <= '0;
      nd_r         <= '0;
      spur_r       <= '0;
      spur_idx_r   <= '0;
      noise_seen_r <= 1'b0;
      clip_r       <= 1'b0;
    end else begin
      peak_r       <= peak_nxt;
      fund_acc_r   <= fund_acc_nxt;
      harm_r       <= harm_nxt;
      noise_r      <= noise_nxt;
      nd_r         <= nd_nxt;
      spur_r       <= spur_nxt;
      spur_idx_r   <= spur_idx_nxt;
      noise_seen_r <= noise_seen_nxt;
      clip_r       <= clip_nxt;
    end
  end

  // result of the frame that ends with this bin
  always_comb begin
    out_data_nxt.peak_power       = peak_nxt;
    out_data_nxt.fund_power       = fund_acc_nxt;
    out_data_nxt.harmonic_power   = harm_nxt;
    out_data_nxt.noise_power      = noise_nxt;
    out_data_nxt.noise_found      = noise_seen_nxt;
    out_data_nxt.noise_dist_power = nd_nxt;
    out_data_nxt.spur_power       = spur_nxt;
    out_data_nxt.spur_bin         = spur_idx_nxt;
    out_data_nxt.saturated        = clip_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && tag3.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && tag3.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/sdm_power.sv */
// two-stage bin power unit: squares, then sum with clipping
module sdm_power (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        v1,
  input  logic [sdm_pkg::SAMPLE_W-1:0] mag_re,
  input  logic [sdm_pkg::SAMPLE_W-1:0] mag_im,
  input  sdm_pkg::bin_tag_t           tag1,
  input  sdm_pkg::pipe_ld_t           ld,
  output sdm_pkg::pipe_vld_t          vld,
  output logic [sdm_pkg::PWR_W-1:0]   pwr,
  output logic                        pwr_clip,
  output sdm_pkg::bin_tag_t           tag3
);

  localparam int SQ_W  = 2 * sdm_pkg::SAMPLE_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int EW    = (SUM_W > sdm_pkg::PWR_W) ? SUM_W : sdm_pkg::PWR_W;

  logic                      v2_r;
  logic                      v3_r;
  logic [SQ_W-1:0]           sq_re_r;
  logic [SQ_W-1:0]           sq_im_r;
  sdm_pkg::bin_tag_t         tag2_r;
  sdm_pkg::bin_tag_t         tag3_r;
  logic [sdm_pkg::PWR_W-1:0] pwr_r;
  logic [sdm_pkg::PWR_W-1:0] pwr_nxt;
  logic                      clip_r;
  logic                      clip_nxt;
  logic [EW-1:0]             re_e;
  logic [EW-1:0]             sum_e;

  // stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld.ld2) v2_r <= v1;
      if (ld.ld3) v3_r <= v2_r;
    end
  end

  // square stage
  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      sq_re_r <= SQ_W'(mag_re) * SQ_W'(mag_re);
      sq_im_r <= SQ_W'(mag_im) * SQ_W'(mag_im);
      tag2_r  <= tag1;
    end
  end

  // dc bin uses re^2, others 4*(re^2+im^2), clipped at the ceiling
  always_comb begin
    re_e  = EW'(sq_re_r);
    sum_e = EW'(sq_re_r) + EW'(sq_im_r);
    if (tag2_r.dc) begin
      clip_nxt = re_e > EW'(sdm_pkg::PWR_MAX);
      pwr_nxt  = clip_nxt ? sdm_pkg::PWR_MAX : sdm_pkg::PWR_W'(re_e);
    end else begin
      clip_nxt = sum_e > EW'(sdm_pkg::PWR_MAX >> 2);
      pwr_nxt  = clip_nxt ? sdm_pkg::PWR_MAX : sdm_pkg::PWR_W'(sum_e << 2);
    end
  end

  // power stage
  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      pwr_r  <= pwr_nxt;
      clip_r <= clip_nxt;
      tag3_r <= tag2_r;
    end
  end

  assign vld.v2   = v2_r;
  assign vld.v3   = v3_r;
  assign pwr      = pwr_r;
  assign pwr_clip = clip_r;
  assign tag3     = tag3_r;

endmodule

/* sv/sdm_checker.sv */
// port-level checks on the result channel, bound to the top level
module sdm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input sdm_pkg::out_item_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // peak bounds the fundamental and the spur
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.peak_power >= out_data.fund_power) &&
                  (out_data.peak_power >= out_data.spur_power))
    else $error("peak below fundamental or spur");

  // spur bin only reported with a nonzero spur
  a_spur_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.spur_power == '0) |-> out_data.spur_bin == '0)
    else $error("spur bin without spur power");

  // noise sum only nonzero when noise bins were seen
  a_noise_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.noise_found |-> out_data.noise_power == '0)
    else $error("noise power without noise bins");

endmodule

bind spectral_distortion_metrics sdm_checker u_sdm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
